[rtl/band_level_meter_peak_hold_assert.svh]
// Assertion helpers shared by the band level meter modules.
// Both expect a clock named clk and a synchronous reset named rst in scope.
`ifndef BAND_LEVEL_METER_PEAK_HOLD_ASSERT_SVH
`define BAND_LEVEL_METER_PEAK_HOLD_ASSERT_SVH

`define BLMPH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define BLMPH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/blmph_pkg.sv]
`timescale 1ns / 1ps
package blmph_pkg;

  localparam int Bands       = 64;
  localparam int BandBits    = 6;
  localparam int BinBits     = 24;
  localparam int LevelBits   = 12;
  localparam int HoldBits    = 8;
  localparam int DbBits      = 8;
  localparam int ExpBits     = 5;
  localparam int LogBits     = 14;
  localparam int ProdBits    = 26;
  localparam int NumBits     = 16;
  localparam int RemBits     = 28;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 12;
  localparam int DbPerLog2   = 1541;
  localparam int DivSteps    = 12;
  localparam int DivCntBits  = 4;

  localparam logic [CfgIdxBits-1:0] CFG_MIN_DB     = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_FULL_SCALE = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_LEVEL_FALL = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_PEAK_HOLD  = 3'd3;
  localparam logic [CfgIdxBits-1:0] CFG_PEAK_FALL  = 3'd4;

  typedef struct packed {
    logic acc;
    logic close;
    logic lz;
    logic logf;
    logic mul;
    logic clamp;
    logic prod;
    logic div_step;
    logic upd;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  typedef struct packed {
    logic [HoldBits-1:0]  hold;
    logic [LevelBits-1:0] peak;
    logic [LevelBits-1:0] bar;
  } band_word_t;

endpackage

[rtl/blmph_ctrl.sv]
`timescale 1ns / 1ps
module blmph_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               bin_valid,
  input  logic               last_in_band,
  output logic               bin_stall,
  input  blmph_pkg::dp_sts_t sts,
  output blmph_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_LZ, S_LOGF, S_MUL, S_CLAMP, S_PROD, S_DIV, S_UPD
  } state_t;

  state_t state;
  logic [blmph_pkg::DivCntBits-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE:  if (bin_valid && last_in_band) state <= S_LZ;
        S_LZ:    state <= S_LOGF;
        S_LOGF:  state <= S_MUL;
        S_MUL:   state <= S_CLAMP;
        S_CLAMP: state <= S_PROD;
        S_PROD: begin
          state <= S_DIV;
          cnt   <= blmph_pkg::DivCntBits'(blmph_pkg::DivSteps - 1);
        end
        S_DIV: begin
          if (cnt == '0) state <= S_UPD;
          else cnt <= cnt - 1'b1;
        end
        S_UPD:   if (sts.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    bin_stall    = (state != S_IDLE);
    cmd.acc      = (state == S_IDLE) && bin_valid;
    cmd.close    = (state == S_IDLE) && bin_valid && last_in_band;
    cmd.lz       = (state == S_LZ);
    cmd.logf     = (state == S_LOGF);
    cmd.mul      = (state == S_MUL);
    cmd.clamp    = (state == S_CLAMP);
    cmd.prod     = (state == S_PROD);
    cmd.div_step = (state == S_DIV);
    cmd.upd      = (state == S_UPD) && sts.out_free;
  end

`include "band_level_meter_peak_hold_assert.svh"
  `BLMPH_ASSERT_NEXT(a_div_to_upd, state == S_DIV && cnt == '0, state == S_UPD, "divider overran")
  `BLMPH_ASSERT_NEXT(a_upd_wait, state == S_UPD && !sts.out_free, state == S_UPD, "update lost")
  `BLMPH_ASSERT(a_cnt_range, state == S_DIV |-> cnt < blmph_pkg::DivCntBits'(blmph_pkg::DivSteps), "bad count")

endmodule

[rtl/blmph_dp.sv]
`timescale 1ns / 1ps
module blmph_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  blmph_pkg::dp_cmd_t                     cmd,
  output blmph_pkg::dp_sts_t                     sts,
  input  logic signed [blmph_pkg::BinBits-1:0]   bin_value,
  input  logic [blmph_pkg::BandBits-1:0]         band_index,
  input  logic                                   cfg_we,
  input  logic [blmph_pkg::CfgIdxBits-1:0]       cfg_index,
  input  logic [blmph_pkg::CfgDataBits-1:0]      cfg_data,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic [blmph_pkg::BandBits-1:0]         band_number,
  output logic [blmph_pkg::LevelBits-1:0]        bar_level,
  output logic [blmph_pkg::LevelBits-1:0]        peak_level
);

  localparam int BB = blmph_pkg::BinBits;
  localparam int LB = blmph_pkg::LevelBits;

  // Configuration registers
  logic signed [blmph_pkg::DbBits-1:0] min_db;
  logic [LB-1:0] full_scale, level_fall, peak_fall;
  logic [blmph_pkg::HoldBits-1:0] peak_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_db     <= -8'sd70;
      full_scale <= 12'd1000;
      level_fall <= 12'd40;
      peak_hold  <= 8'd40;
      peak_fall  <= 12'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        blmph_pkg::CFG_MIN_DB:     min_db     <= cfg_data[blmph_pkg::DbBits-1:0];
        blmph_pkg::CFG_FULL_SCALE: full_scale <= cfg_data[LB-1:0];
        blmph_pkg::CFG_LEVEL_FALL: level_fall <= cfg_data[LB-1:0];
        blmph_pkg::CFG_PEAK_HOLD:  peak_hold  <= cfg_data[blmph_pkg::HoldBits-1:0];
        blmph_pkg::CFG_PEAK_FALL:  peak_fall  <= cfg_data[LB-1:0];
        default: ;
      endcase
    end
  end

  // Magnitude and running maximum
  logic [BB-1:0] mag, rmax, max_next, m_r;
  logic [blmph_pkg::BandBits-1:0] band_r;

  always_comb begin
    mag      = bin_value[BB-1] ? (~bin_value + 1'b1) : bin_value;
    max_next = (mag > rmax) ? mag : rmax;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rmax <= '0;
    end else if (cmd.acc) begin
      rmax <= cmd.close ? '0 : max_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.close) begin
      m_r    <= max_next;
      band_r <= band_index;
    end
  end

  // Band store with one valid bit per band, so reset reads as all zero.
  blmph_pkg::band_word_t mem [blmph_pkg::Bands];
  blmph_pkg::band_word_t rd, stored, wr;
  logic [blmph_pkg::Bands-1:0] vld;
  logic rd_vld;

  always_ff @(posedge clk) begin
    if (cmd.close) rd <= mem[band_index];
    if (cmd.upd) mem[band_r] <= wr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.close) rd_vld <= vld[band_index];
      if (cmd.upd) vld[band_r] <= 1'b1;
    end
  end

  // Leading one, then log2 in Q.8
  logic [blmph_pkg::ExpBits-1:0] e_c, e_r;
  logic zero_r;
  logic [BB-1:0] norm;
  logic [blmph_pkg::LogBits-9:0] le;
  logic signed [blmph_pkg::LogBits-1:0] l_r;

  always_comb begin
    e_c = '0;
    for (int k = 0; k < BB; k++) begin
      if (m_r[k]) e_c = blmph_pkg::ExpBits'(k);
    end
    norm = m_r << (blmph_pkg::ExpBits'(BB - 1) - e_r);
    le   = (blmph_pkg::LogBits - 8)'(e_r) - (blmph_pkg::LogBits - 8)'(BB - 1);
  end

  always_ff @(posedge clk) begin
    if (cmd.lz) begin
      e_r    <= e_c;
      zero_r <= (m_r == '0);
    end
    if (cmd.logf) l_r <= {le, norm[BB-2 -: 8]};
  end

  // dB in Q.8 and distance above the floor in Q8.8
  logic signed [11:0] k_db;
  logic signed [blmph_pkg::ProdBits-1:0] p_r;
  logic signed [blmph_pkg::ProdBits-9:0] db;
  logic [blmph_pkg::DbBits-1:0] nfl;
  logic [blmph_pkg::NumBits-1:0] dvs, num_r;
  logic signed [blmph_pkg::ProdBits-8:0] above;

  always_comb begin
    k_db  = 12'(blmph_pkg::DbPerLog2);
    db    = p_r[blmph_pkg::ProdBits-1:8];
    nfl   = min_db[blmph_pkg::DbBits-1] ? blmph_pkg::DbBits'(-min_db) : 8'd1;
    dvs   = {nfl, 8'b0};
    above = (blmph_pkg::ProdBits - 7)'(db) + $signed({3'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) p_r <= l_r * k_db;
    if (cmd.clamp) begin
      num_r <= (zero_r || above < 0) ? '0 : above[blmph_pkg::NumBits-1:0];
    end
  end

  // Restoring divider for full_scale * num / -floor, one quotient bit a cycle
  logic [blmph_pkg::RemBits-1:0] rem, dsh;
  logic [LB-1:0] quot;

  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      rem  <= blmph_pkg::RemBits'(full_scale) * blmph_pkg::RemBits'(num_r);
      dsh  <= blmph_pkg::RemBits'(dvs) << (blmph_pkg::DivSteps - 1);
      quot <= '0;
    end else if (cmd.div_step) begin
      if (rem >= dsh) begin
        rem  <= rem - dsh;
        quot <= {quot[LB-2:0], 1'b1};
      end else begin
        quot <= {quot[LB-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  // Bar and peak update
  logic [LB-1:0] bar_dec, bar_up, peak_t;
  logic [blmph_pkg::HoldBits-1:0] hold_t;

  always_comb begin
    stored  = rd_vld ? rd : '0;
    bar_dec = (stored.bar > level_fall) ? stored.bar - level_fall : '0;
    bar_up  = (bar_dec < quot) ? quot : bar_dec;
    wr.bar  = (bar_up > full_scale) ? full_scale : bar_up;
    if (stored.hold >= peak_hold) begin
      peak_t = (stored.peak > peak_fall) ? stored.peak - peak_fall : '0;
      hold_t = stored.hold;
    end else begin
      peak_t = stored.peak;
      hold_t = stored.hold + 1'b1;
    end
    if (peak_t < quot) begin
      wr.peak = quot;
      wr.hold = '0;
    end else begin
      wr.peak = peak_t;
      wr.hold = hold_t;
    end
  end

  // Output register
  assign sts.out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.upd) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      band_number <= band_r;
      bar_level   <= wr.bar;
      peak_level  <= wr.peak;
    end
  end

`include "band_level_meter_peak_hold_assert.svh"
  `BLMPH_ASSERT(a_target_le_fs, cmd.upd |-> quot <= full_scale, "target above full scale")
  `BLMPH_ASSERT_NEXT(a_max_cleared, cmd.close, rmax == '0, "running max not cleared")
  `BLMPH_ASSERT(a_out_from_upd, $rose(result_valid) |-> $past(cmd.upd), "result without update")

endmodule

[rtl/band_level_meter_peak_hold.sv]
`timescale 1ns / 1ps
// Spectrum bar meter with peak hold. Bins are taken one per cycle while the block is idle; the
// bin flagged last_in_band closes its band and holds the bin side stalled through its steps
// (leading-one search, log2, dB multiply, clamp, product, a restoring divider for the level
// mapping, then the store update), longer only if the previous result is still waiting
// to be taken. One result per closed band leaves through a registered output. Band state
// lives in a 64-entry memory with a valid bit per band, so it reads as zero after reset
// without a clearing pass.
module band_level_meter_peak_hold (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 bin_valid,
  output logic                                 bin_stall,
  input  logic signed [blmph_pkg::BinBits-1:0] bin_value,
  input  logic [blmph_pkg::BandBits-1:0]       band_index,
  input  logic                                 last_in_band,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [blmph_pkg::BandBits-1:0]       band_number,
  output logic [blmph_pkg::LevelBits-1:0]      bar_level,
  output logic [blmph_pkg::LevelBits-1:0]      peak_level,
  input  logic                                 cfg_we,
  input  logic [blmph_pkg::CfgIdxBits-1:0]     cfg_index,
  input  logic [blmph_pkg::CfgDataBits-1:0]    cfg_data
);

  blmph_pkg::dp_cmd_t cmd;
  blmph_pkg::dp_sts_t sts;

  blmph_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .bin_valid    (bin_valid),
    .last_in_band (last_in_band),
    .bin_stall    (bin_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  blmph_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .bin_value    (bin_value),
    .band_index   (band_index),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .band_number  (band_number),
    .bar_level    (bar_level),
    .peak_level   (peak_level)
  );

endmodule
